FILE: design/rmsm_pkg.sv
// rmsm_pkg: shared constants and types for the block rms meter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rmsm_pkg;

  // default configuration
  localparam int DEF_MAX_SAMPLES = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  // fixed result field widths
  localparam int RMS_W  = 16;
  localparam int USED_W = 6;
  localparam int SEQ_W  = 32;

  // the running sum is at most this many bits wide; it saturates at its width
  localparam int SUM_CAP_W = 64;

  // depth of the queue of finished block records
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

FILE: design/rmsm_front.sv
// rmsm_front: takes items, squares samples and accumulates each block
// depends on rmsm_pkg; pushes one record per block into rmsm_queue
`timescale 1ns / 1ps
`default_nettype none

module rmsm_front #(
  parameter int MAX_SAMPLES = rmsm_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = rmsm_pkg::DEF_SAMPLE_BITS,
  parameter int CNT_W       = 6,
  parameter int ACC_W       = 37
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          has_sample,
  input  wire logic                          last,
  input  wire logic [rmsm_pkg::SEQ_W-1:0]    sequence_req,
  input  wire rmsm_pkg::queue_stat_t         q_stat,
  output logic                               push,
  output logic [ACC_W-1:0]                   push_sum,
  output logic [CNT_W-1:0]                   push_cnt,
  output logic [rmsm_pkg::SEQ_W-1:0]         push_seq
);

  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic                       accept;
  logic [SAMPLE_BITS-1:0]     mag;
  logic                       s1_valid;
  logic                       s1_has;
  logic                       s1_last;
  logic [rmsm_pkg::SEQ_W-1:0] s1_seq;
  logic [SQ_W-1:0]            s1_square;
  logic [ACC_W-1:0]           square_sum;
  logic [CNT_W-1:0]           sample_tally;
  logic                       take;
  logic [ACC_W:0]             sum_ext;
  logic [ACC_W-1:0]           square_sum_next;
  logic [CNT_W-1:0]           sample_tally_next;

  // one item in flight, and the queue must have room for its record
  assign busy   = s1_valid || q_stat.full;
  assign accept = start && !busy;

  // magnitude of the two's complement sample; the most negative code maps to itself
  assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_has    <= has_sample;
      s1_last   <= last;
      s1_seq    <= sequence_req;
      s1_square <= mag * mag;
    end
  end

  assign take    = s1_valid && s1_has && (sample_tally < CNT_W'(MAX_SAMPLES));
  assign sum_ext = {1'b0, square_sum} + {1'b0, ACC_W'(s1_square)};

  always_comb begin
    square_sum_next   = square_sum;
    sample_tally_next = sample_tally;
    if (take) begin
      square_sum_next   = sum_ext[ACC_W] ? '1 : sum_ext[ACC_W-1:0];
      sample_tally_next = sample_tally + 1'b1;
    end
  end

  assign push     = s1_valid && s1_last;
  assign push_sum = square_sum_next;
  assign push_cnt = sample_tally_next;
  assign push_seq = s1_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum   <= '0;
      sample_tally <= '0;
    end else if (push) begin
      square_sum   <= '0;
      sample_tally <= '0;
    end else begin
      square_sum   <= square_sum_next;
      sample_tally <= sample_tally_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/rmsm_queue.sv
// rmsm_queue: short first-in first-out queue of block records
// depends on rmsm_pkg for the status struct and the default depth
`timescale 1ns / 1ps
`default_nettype none

module rmsm_queue #(
  parameter int W     = 8,
  parameter int DEPTH = rmsm_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic [W-1:0]           push_data,
  input  wire logic                   pop,
  output logic [W-1:0]                head,
  output rmsm_pkg::queue_stat_t       q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (fill == CNT_W'(DEPTH));
  assign q_stat.empty = (fill == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/rmsm_back.sv
// rmsm_back: serial divide of the block sum by its count, then serial square root
// depends on rmsm_pkg; reads records from rmsm_queue, drives the result ports
`timescale 1ns / 1ps
`default_nettype none

module rmsm_back #(
  parameter int CNT_W = 6,
  parameter int ACC_W = 37
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rmsm_pkg::queue_stat_t         q_stat,
  input  wire logic [ACC_W-1:0]              head_sum,
  input  wire logic [CNT_W-1:0]              head_cnt,
  input  wire logic [rmsm_pkg::SEQ_W-1:0]    head_seq,
  output logic                               pop,
  output logic                               valid,
  output logic [rmsm_pkg::RMS_W-1:0]         rms,
  output logic [rmsm_pkg::USED_W-1:0]        used_count,
  output logic                               seq_gap,
  output logic [rmsm_pkg::SEQ_W-1:0]         blocks_done
);

  localparam int QW     = ACC_W + (ACC_W % 2);
  localparam int ROOT_W = QW / 2;
  localparam int ITER_W = $clog2(ACC_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                     state;
  logic [ITER_W-1:0]          iter;
  logic [ACC_W-1:0]           quo;
  logic [CNT_W-1:0]           dvs;
  logic [CNT_W-1:0]           rem_d;
  logic [QW-1:0]              rad;
  logic [ROOT_W:0]            rem_s;
  logic [ROOT_W-1:0]          root;
  logic [rmsm_pkg::SEQ_W-1:0] seq_hold;
  logic [rmsm_pkg::SEQ_W-1:0] prev_sequence;
  logic [rmsm_pkg::SEQ_W-1:0] block_tally;

  // one quotient bit per cycle
  logic [CNT_W:0]   div_try;
  logic             div_ge;
  logic [CNT_W-1:0] rem_d_next;
  logic [ACC_W-1:0] quo_next;

  // one root bit per cycle
  logic [ROOT_W+2:0] root_acc;
  logic [ROOT_W+2:0] root_trial;
  logic              root_ge;
  logic [ROOT_W:0]   rem_s_next;
  logic [ROOT_W-1:0] root_next;

  always_comb begin
    div_try    = {rem_d, quo[ACC_W-1]};
    div_ge     = (div_try >= {1'b0, dvs});
    rem_d_next = div_ge ? CNT_W'(div_try - {1'b0, dvs}) : div_try[CNT_W-1:0];
    quo_next   = {quo[ACC_W-2:0], div_ge};
  end

  always_comb begin
    root_acc   = {rem_s, rad[QW-1:QW-2]};
    root_trial = (ROOT_W + 3)'({root, 2'b01});
    root_ge    = (root_acc >= root_trial);
    rem_s_next = root_ge ? (ROOT_W + 1)'(root_acc - root_trial)
                         : root_acc[ROOT_W:0];
    root_next  = {root[ROOT_W-2:0], root_ge};
  end

  assign pop = (state == ST_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= 1'b0;
      prev_sequence <= '0;
      block_tally   <= '0;
    end else begin
      valid <= (state == ST_DONE);
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            state <= (head_cnt == '0) ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (iter == ITER_W'(1)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (iter == ITER_W'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          block_tally   <= block_tally + 1'b1;
          prev_sequence <= seq_hold;
          state         <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        quo      <= head_sum;
        dvs      <= head_cnt;
        seq_hold <= head_seq;
        rem_d    <= '0;
        root     <= '0;
        iter     <= ITER_W'(ACC_W);
      end
      ST_DIV: begin
        quo   <= quo_next;
        rem_d <= rem_d_next;
        if (iter == ITER_W'(1)) begin
          rad   <= QW'(quo_next);
          rem_s <= '0;
          root  <= '0;
          iter  <= ITER_W'(ROOT_W);
        end else begin
          iter <= iter - 1'b1;
        end
      end
      ST_ROOT: begin
        rad   <= {rad[QW-3:0], 2'b00};
        rem_s <= rem_s_next;
        root  <= root_next;
        iter  <= iter - 1'b1;
      end
      ST_DONE: begin
        rms         <= rmsm_pkg::RMS_W'(root);
        used_count  <= rmsm_pkg::USED_W'(dvs);
        seq_gap     <= (prev_sequence != '0) && (seq_hold != prev_sequence + 1'b1);
        blocks_done <= block_tally + 1'b1;
      end
      default: begin
        iter <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/block_rms_meter_core.sv
// block_rms_meter_core: top level of the block rms meter
// depends on rmsm_pkg, rmsm_front, rmsm_queue and rmsm_back
//
//  channel   handshake            fields                                     direction
//  items     start / busy         sample, has_sample, last, sequence_req     in
//  results   valid (one cycle)    rms, used_count, seq_gap, blocks_done      out
//
// an item transfer happens at an edge with start high and busy low; busy is
// high for the cycle after each transfer while the square is accumulated,
// so the front end takes no new item until the last one is accumulated
// on a last item the block record (sum, count, sequence) enters a 2-entry
// queue; the back end loads a record, divides the sum by the count, takes
// the square root and writes the result; an empty block skips the divide
// and the root and goes straight from loading to writing the result
// busy also stays high while the queue is full; results are never held off
// rst is synchronous and clears the sums, counters and sequence history
`timescale 1ns / 1ps
`default_nettype none

module block_rms_meter_core #(
  parameter int MAX_SAMPLES = rmsm_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = rmsm_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          has_sample,
  input  wire logic                          last,
  input  wire logic [rmsm_pkg::SEQ_W-1:0]    sequence_req,
  // result channel
  output logic                               valid,
  output logic [rmsm_pkg::RMS_W-1:0]         rms,
  output logic [rmsm_pkg::USED_W-1:0]        used_count,
  output logic                               seq_gap,
  output logic [rmsm_pkg::SEQ_W-1:0]         blocks_done
);

  // sample counter holds 0 to MAX_SAMPLES
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  // enough bits for MAX_SAMPLES full-scale squares, capped where the sum saturates
  localparam int SUM_FULL = 2 * SAMPLE_BITS - 1 + CNT_W;
  localparam int ACC_W    = (SUM_FULL > rmsm_pkg::SUM_CAP_W) ? rmsm_pkg::SUM_CAP_W : SUM_FULL;
  localparam int REC_W    = ACC_W + CNT_W + rmsm_pkg::SEQ_W;

  rmsm_pkg::queue_stat_t      q_stat;
  logic                       push;
  logic [ACC_W-1:0]           push_sum;
  logic [CNT_W-1:0]           push_cnt;
  logic [rmsm_pkg::SEQ_W-1:0] push_seq;
  logic                       pop;
  logic [REC_W-1:0]           head;

  // front end: squares and accumulates, closes blocks
  rmsm_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .ACC_W       (ACC_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .has_sample   (has_sample),
    .last         (last),
    .sequence_req (sequence_req),
    .q_stat       (q_stat),
    .push         (push),
    .push_sum     (push_sum),
    .push_cnt     (push_cnt),
    .push_seq     (push_seq)
  );

  // finished block records waiting for the back end
  rmsm_queue #(
    .W     (REC_W),
    .DEPTH (rmsm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_sum, push_cnt, push_seq}),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back end: mean, square root, sequence check and block count
  rmsm_back #(
    .CNT_W (CNT_W),
    .ACC_W (ACC_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head_sum    (head[REC_W-1 -: ACC_W]),
    .head_cnt    (head[rmsm_pkg::SEQ_W +: CNT_W]),
    .head_seq    (head[rmsm_pkg::SEQ_W-1:0]),
    .pop         (pop),
    .valid       (valid),
    .rms         (rms),
    .used_count  (used_count),
    .seq_gap     (seq_gap),
    .blocks_done (blocks_done)
  );

endmodule

`default_nettype wire

FILE: test/rmsm_block_checker.sv
// rmsm_block_checker: watches the item and result channels of the block rms meter,
// predicts each block result and compares it field by field
// depends on rmsm_pkg
`timescale 1ns / 1ps

module rmsm_block_checker #(
  parameter int MAX_SAMPLES = rmsm_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = rmsm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          has_sample,
  input  logic                          last,
  input  logic [rmsm_pkg::SEQ_W-1:0]    sequence_req,
  input  logic                          valid,
  input  logic [rmsm_pkg::RMS_W-1:0]    rms,
  input  logic [rmsm_pkg::USED_W-1:0]   used_count,
  input  logic                          seq_gap,
  input  logic [rmsm_pkg::SEQ_W-1:0]    blocks_done,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    logic [rmsm_pkg::RMS_W-1:0]  rms;
    logic [rmsm_pkg::USED_W-1:0] used;
    logic                        gap;
    logic [rmsm_pkg::SEQ_W-1:0]  done;
  } block_result_t;

  localparam logic [rmsm_pkg::SUM_CAP_W-1:0] SUM_SAT = '1;

  block_result_t                  pending_blocks[$];
  logic [rmsm_pkg::SUM_CAP_W-1:0] energy_sum;
  int unsigned                    samples_taken;
  logic [rmsm_pkg::SEQ_W-1:0]     last_block_seq;
  logic [rmsm_pkg::SEQ_W-1:0]     block_count;

  // bit-by-bit floor square root
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0]  root;
    logic [63:0]  trial;
    logic [127:0] trial_sq;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial    = root | (64'd1 << b);
      trial_sq = {64'd0, trial} * {64'd0, trial};
      if (trial_sq <= {64'd0, v})
        root = trial;
    end
    return root;
  endfunction

  task automatic fold_sample(logic signed [SAMPLE_BITS-1:0] s);
    longint                         wide;
    logic [rmsm_pkg::SUM_CAP_W-1:0] sq;
    wide = longint'(s);
    if (wide < 0)
      wide = -wide;
    sq = wide * wide;
    if (energy_sum > SUM_SAT - sq)
      energy_sum = SUM_SAT;
    else
      energy_sum = energy_sum + sq;
    samples_taken++;
  endtask

  task automatic close_block(logic [rmsm_pkg::SEQ_W-1:0] seq);
    block_result_t r;
    logic [63:0]   mean;
    r.rms = '0;
    if (samples_taken != 0) begin
      mean  = energy_sum / samples_taken;
      r.rms = rmsm_pkg::RMS_W'(floor_root(mean));
    end
    block_count = block_count + 1'b1;
    r.used = rmsm_pkg::USED_W'(samples_taken);
    r.gap  = (last_block_seq != 0) && (seq != last_block_seq + 1'b1);
    r.done = block_count;
    last_block_seq = seq;
    energy_sum     = '0;
    samples_taken  = 0;
    pending_blocks.push_back(r);
  endtask

  task automatic report_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    block_result_t want;
    if (rst) begin
      pending_blocks.delete();
      energy_sum     = '0;
      samples_taken  = 0;
      last_block_seq = '0;
      block_count    = '0;
    end else begin
      // item transfer
      if (start && !busy) begin
        if (has_sample && samples_taken < MAX_SAMPLES)
          fold_sample(sample);
        if (last)
          close_block(sequence_req);
      end
      // result transfer
      if (valid) begin
        if (pending_blocks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rms %0d used %0d gap %0d done %0d",
                   $time, rms, used_count, seq_gap, blocks_done);
          mismatches++;
        end else begin
          want = pending_blocks.pop_front();
          report_field("rms", 64'(want.rms), 64'(rms));
          report_field("used_count", 64'(want.used), 64'(used_count));
          report_field("seq_gap", 64'(want.gap), 64'(seq_gap));
          report_field("blocks_done", 64'(want.done), 64'(blocks_done));
        end
      end
    end
    outstanding = pending_blocks.size();
  end

endmodule

FILE: test/tb.sv
// tb: stimulus and verdict for block_rms_meter_core
// depends on rmsm_pkg, block_rms_meter_core and rmsm_block_checker
`timescale 1ns / 1ps

module tb;

  localparam int SB           = rmsm_pkg::DEF_SAMPLE_BITS;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  // extra wait after the last result, so this covers any straggler
  localparam int SETTLE       = 150;

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic signed [SB-1:0]            sample;
  logic                            has_sample;
  logic                            last;
  logic [rmsm_pkg::SEQ_W-1:0]      sequence_req;
  logic                            valid;
  logic [rmsm_pkg::RMS_W-1:0]      rms;
  logic [rmsm_pkg::USED_W-1:0]     used_count;
  logic                            seq_gap;
  logic [rmsm_pkg::SEQ_W-1:0]      blocks_done;

  int                              mismatches;
  int                              outstanding;
  int                              cycles;
  int                              counted_items;  // transfers that carry a sample or end a block
  int                              sender_idle_pct;
  logic [rmsm_pkg::SEQ_W-1:0]      sent_seq;       // sequence of the latest block end sent

  block_rms_meter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .has_sample   (has_sample),
    .last         (last),
    .sequence_req (sequence_req),
    .valid        (valid),
    .rms          (rms),
    .used_count   (used_count),
    .seq_gap      (seq_gap),
    .blocks_done  (blocks_done)
  );

  rmsm_block_checker level_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .has_sample   (has_sample),
    .last         (last),
    .sequence_req (sequence_req),
    .valid        (valid),
    .rms          (rms),
    .used_count   (used_count),
    .seq_gap      (seq_gap),
    .blocks_done  (blocks_done),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one item transfer; inputs move only at the falling edge and start is
  // assigned at most once per edge, so a back-to-back item keeps start high
  task automatic send_item(logic [SB-1:0] s, logic h, logic l, logic [rmsm_pkg::SEQ_W-1:0] q);
    while ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    sample       = s;
    has_sample   = h;
    last         = l;
    sequence_req = q;
    start        = 1'b1;
    // transfer happens at the first rising edge with busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (h || l)
      counted_items++;
    if (l)
      sent_seq = q;
  endtask

  // hold the sender off until every block result has come back
  task automatic drain_results();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // full-scale values, zero and all-ones now and then, otherwise any 16-bit pattern
  function automatic logic [SB-1:0] pick_sample();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return SB'($urandom);
    endcase
  endfunction

  // mostly the successor, with jumps, zero, wrap and repeats mixed in
  function automatic logic [rmsm_pkg::SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(99);
    if (r < 70)      return sent_seq + 1'b1;
    else if (r < 80) return $urandom;
    else if (r < 85) return '0;
    else if (r < 90) return '1;
    else             return sent_seq;
  endfunction

  // short blocks dominate; some go past the sample cap
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 60)      return $urandom_range(1, 8);
    else if (r < 85) return $urandom_range(9, 31);
    else             return $urandom_range(32, 40);
  endfunction

  task automatic random_block();
    int   kind;
    int   len;
    logic end_has;
    logic [rmsm_pkg::SEQ_W-1:0] q;
    kind = $urandom_range(99);
    if (kind < 8) begin
      // noise: every flag and field unconstrained
      repeat ($urandom_range(1, 6))
        send_item(SB'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    end else begin
      // empty blocks in a small share, otherwise a run of samples
      len     = (kind < 13) ? 0 : pick_len();
      end_has = (kind >= 13) && ($urandom_range(4) != 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0)
          send_item(SB'($urandom), 1'b0, 1'b0, $urandom);  // idle item, changes nothing
        send_item(pick_sample(), 1'b1, 1'b0, $urandom);
      end
      q = pick_seq();
      send_item(end_has ? pick_sample() : SB'($urandom), end_has, 1'b1, q);
    end
  endtask

  initial begin
    int target;
    int phase;
    int active_phase;

    // every input known from time zero
    rst             = 1'b1;
    start           = 1'b0;
    sample          = '0;
    has_sample      = 1'b0;
    last            = 1'b0;
    sequence_req    = '0;
    counted_items   = 0;
    sender_idle_pct = 0;
    sent_seq        = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    // empty block straight after reset, stored sequence still zero
    send_item(16'h0000, 1'b0, 1'b1, 32'd0);
    // idle item gives nothing
    send_item(16'h1234, 1'b0, 1'b0, 32'hdead_beef);
    // full-scale negative alone gives the largest rms
    send_item(16'h8000, 1'b1, 1'b1, 32'd5);
    send_item(16'h7fff, 1'b1, 1'b1, 32'd6);
    // small values, then an end item without a sample and a sequence jump
    send_item(16'h0000, 1'b1, 1'b0, 32'd0);
    send_item(16'h0001, 1'b1, 1'b0, 32'hffff_ffff);
    send_item(16'hffff, 1'b1, 1'b0, 32'd0);
    send_item(16'h5555, 1'b0, 1'b1, 32'd8);
    // mixed signs in one block, in-order sequence
    send_item(16'h8000, 1'b1, 1'b0, 32'd0);
    send_item(16'h7fff, 1'b1, 1'b0, 32'd0);
    send_item(16'haaaa, 1'b1, 1'b1, 32'd9);
    // sequence wraps through all-ones to zero, then zero never flags a gap
    send_item(16'h4000, 1'b1, 1'b1, 32'hffff_ffff);
    send_item(16'hc000, 1'b1, 1'b1, 32'd0);
    send_item(16'h0000, 1'b0, 1'b1, 32'd7);
    // repeated sequence is a gap
    send_item(16'h0100, 1'b1, 1'b1, 32'd7);
    drain_results();

    // random part in idling phases: none, heavy, none, light
    target       = counted_items + RANDOM_ITEMS;
    active_phase = 0;
    while (counted_items < target) begin
      phase = (RANDOM_ITEMS - (target - counted_items)) * 4 / RANDOM_ITEMS;
      if (phase > 3)
        phase = 3;
      if (phase != active_phase) begin
        drain_results();
        active_phase = phase;
      end
      case (phase)
        1:       sender_idle_pct = 80;
        3:       sender_idle_pct = 11;
        default: sender_idle_pct = 0;
      endcase
      random_block();
    end

    // all items sent: wait for the back end to finish
    drain_results();

    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
